// ===== hw/rtl/ticks_to_local_calendar_date_defines.svh =====
// ============================================================================
// Tick to local calendar date: assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ============================================================================
`ifndef TICKS_TO_LOCAL_CALENDAR_DATE_DEFINES_SVH
`define TICKS_TO_LOCAL_CALENDAR_DATE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TLCD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TLCD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tlcd_pkg.sv =====
// ============================================================================
// Tick to local calendar date: package
// Shared types, register map, constants and calendar helper functions.
// ============================================================================
package tlcd_pkg;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 64;

   // Register indexes, taken from paddr[4:3] (registers lie 8 bytes apart).
   localparam logic [1:0] REG_BASE_SECONDS     = 2'd0;
   localparam logic [1:0] REG_BASE_TICK_COUNT  = 2'd1;
   localparam logic [1:0] REG_ZONE_HOURS       = 2'd2;
   localparam logic [1:0] REG_TICKS_PER_SECOND = 2'd3;

   localparam logic [19:0] TICKS_PER_SECOND_RESET = 20'd100;

   localparam logic [15:0] SECS_PER_HOUR = 16'd3600;
   localparam logic [11:0] FIRST_YEAR    = 12'd1970;
   localparam logic [11:0] LAST_YEAR     = 12'd2106;
   localparam logic [11:0] SKIPPED_LEAP  = 12'd2100;
   localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;
   localparam logic [3:0]  LAST_MONTH    = 4'd12;
   localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
   localparam logic [5:0]  MINS_PER_HOUR = 6'd60;
   localparam logic [5:0]  HOURS_PER_DAY = 6'd24;

   typedef struct packed {
      logic [31:0]        base_seconds;
      logic [63:0]        base_tick_count;
      logic signed [4:0]  zone_hours;
      logic [19:0]        ticks_per_second;
   } cfg_type;

   typedef struct packed {
      logic load_tick;
      logic div_step;
      logic latch_utc;
      logic load_local;
      logic load_min;
      logic load_hour;
      logic start_cal;
      logic year_step;
      logic month_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic year_end;
      logic month_end;
   } sts_type;

   // Years 1970 to 2106 hold only one century year that is not a leap year.
   function automatic logic is_leap(input logic [11:0] year);
      is_leap = (year[1:0] == 2'b00) && (year != SKIPPED_LEAP);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] days;
      case (month)
         4'd2: days = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: days = 5'd30;
         default: days = 5'd31;
      endcase
      month_days = days;
   endfunction

   function automatic logic [2:0] mod7(input logic [4:0] value);
      logic [4:0] v;
      v = value;
      for (int i = 0; i < 4; i++) begin
         if (v >= 5'd7) begin
            v = v - 5'd7;
         end
      end
      mod7 = v[2:0];
   endfunction

   function automatic logic [2:0] add_mod7(input logic [2:0] a, input logic [2:0] b);
      logic [3:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= 4'd7) begin
         s = s - 4'd7;
      end
      add_mod7 = s[2:0];
   endfunction

endpackage

// ===== hw/rtl/ticks_to_local_calendar_date.sv =====
// ============================================================================
// Tick to local calendar date: top level
// Converts a 64-bit timer tick count into a local Gregorian date and time.
// ============================================================================
// A tick count transferred on the req_ channel is turned into one result
// transfer on the rsp_ channel. Elapsed seconds are the tick difference from
// base_tick_count (modulo 2^64) divided by ticks_per_second, with a zero rate
// giving zero seconds; the low 32 bits are added to base_seconds, and the
// zone_hours offset is applied, clamping to the epoch when a negative offset
// would go below it and wrapping modulo 2^32 otherwise. A shared restoring
// divider that retires two quotient bits per cycle performs the 64-bit tick
// division and the divisions by 60, 60 and 24, and the calendar walk then
// steps one year per cycle (up to 136 steps from 1970) and one month per
// cycle (up to 11 steps).
// The block takes a new item only when the previous one has left the
// datapath; the result sits in an output register, so the next transfer
// is accepted while an earlier result is still waiting on rsp_stall.
// Configuration registers sit at byte addresses 0, 8, 16 and 24 of a
// 64-bit APB-style port and are to be written only while the block is idle.

module ticks_to_local_calendar_date (
   input  logic                              clock,
   input  logic                              reset,
   // Input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [63:0]                       req_tick_now,
   // Result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [11:0]                       rsp_year_out,
   output logic [3:0]                        rsp_month_out,
   output logic [4:0]                        rsp_day_out,
   output logic [4:0]                        rsp_hour_out,
   output logic [5:0]                        rsp_minute_out,
   output logic [5:0]                        rsp_second_out,
   output logic [2:0]                        rsp_weekday_out,
   // Configuration port
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tlcd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tlcd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tlcd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   tlcd_pkg::cfg_type cfg;
   tlcd_pkg::cmd_type cmd;
   tlcd_pkg::sts_type sts;

   // Register file; the user keeps its outputs constant while an item is in flight; the block does not enforce this.
   tlcd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // The controller owns both handshakes and issues at most one command per cycle.
   tlcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // The datapath holds the divider, the calendar walk and the result register.
   tlcd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd         (cmd),
      .sts         (sts),
      .tick_now    (req_tick_now),
      .year_out    (rsp_year_out),
      .month_out   (rsp_month_out),
      .day_out     (rsp_day_out),
      .hour_out    (rsp_hour_out),
      .minute_out  (rsp_minute_out),
      .second_out  (rsp_second_out),
      .weekday_out (rsp_weekday_out)
   );

endmodule

// ===== hw/rtl/tlcd_csr.sv =====
// ============================================================================
// Tick to local calendar date: configuration registers
// APB-style register file holding the baseline, zone offset and tick rate.
// ============================================================================
module tlcd_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tlcd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [tlcd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [tlcd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output tlcd_pkg::cfg_type                 cfg
);

   tlcd_pkg::cfg_type cfg_ff;
   tlcd_pkg::cfg_type cfg_in;
   logic              wr_en;
   logic [1:0]        reg_idx;

   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = csr_paddr[4:3];
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            tlcd_pkg::REG_BASE_SECONDS:     cfg_in.base_seconds     = csr_pwdata[31:0];
            tlcd_pkg::REG_BASE_TICK_COUNT:  cfg_in.base_tick_count  = csr_pwdata;
            tlcd_pkg::REG_ZONE_HOURS:       cfg_in.zone_hours       = csr_pwdata[4:0];
            tlcd_pkg::REG_TICKS_PER_SECOND: cfg_in.ticks_per_second = csr_pwdata[19:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         tlcd_pkg::REG_BASE_SECONDS:     csr_prdata = {32'd0, cfg_ff.base_seconds};
         tlcd_pkg::REG_BASE_TICK_COUNT:  csr_prdata = cfg_ff.base_tick_count;
         tlcd_pkg::REG_ZONE_HOURS:       csr_prdata = {59'd0, cfg_ff.zone_hours};
         tlcd_pkg::REG_TICKS_PER_SECOND: csr_prdata = {44'd0, cfg_ff.ticks_per_second};
         default: csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.base_seconds     <= '0;
         cfg_ff.base_tick_count  <= '0;
         cfg_ff.zone_hours       <= '0;
         cfg_ff.ticks_per_second <= tlcd_pkg::TICKS_PER_SECOND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hw/rtl/tlcd_datapath.sv =====
// ============================================================================
// Tick to local calendar date: datapath
// Shared two-bit-per-cycle divider, zone adjust, calendar walk, result register.
// ============================================================================
`include "ticks_to_local_calendar_date_defines.svh"

module tlcd_datapath (
   input  logic               clock,
   input  logic               reset,
   input  tlcd_pkg::cfg_type  cfg,
   input  tlcd_pkg::cmd_type  cmd,
   output tlcd_pkg::sts_type  sts,
   input  logic [63:0]        tick_now,
   output logic [11:0]        year_out,
   output logic [3:0]         month_out,
   output logic [4:0]         day_out,
   output logic [4:0]         hour_out,
   output logic [5:0]         minute_out,
   output logic [5:0]         second_out,
   output logic [2:0]         weekday_out
);

   // Divider: quo_ff shifts the dividend out at the top and quotient bits in at the bottom.
   logic [63:0] quo_ff, quo_in;
   logic [19:0] rem_ff, rem_in;
   logic [19:0] dvs_ff, dvs_in;
   logic [31:0] utc_ff, utc_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [15:0] days_ff, days_in;
   logic [2:0]  wd_ff, wd_in;

   logic [11:0] year_out_ff;
   logic [3:0]  month_out_ff;
   logic [4:0]  day_out_ff;
   logic [4:0]  hour_out_ff;
   logic [5:0]  minute_out_ff;
   logic [5:0]  second_out_ff;
   logic [2:0]  weekday_out_ff;

   logic [20:0] part1, part2;
   logic        ge1, ge2;
   logic [19:0] rem1, rem2;
   logic [31:0] elapsed;
   logic        zone_neg;
   logic [4:0]  zone_mag;
   logic [15:0] zone_shift;
   logic [31:0] local_t;
   logic        leap;
   logic [8:0]  year_len;
   logic [4:0]  mon_len;

   // Two restoring division steps per cycle.
   always_comb begin
      part1 = {rem_ff, quo_ff[63]};
      ge1   = part1 >= {1'b0, dvs_ff};
      rem1  = ge1 ? 20'(part1 - {1'b0, dvs_ff}) : part1[19:0];
      part2 = {rem1, quo_ff[62]};
      ge2   = part2 >= {1'b0, dvs_ff};
      rem2  = ge2 ? 20'(part2 - {1'b0, dvs_ff}) : part2[19:0];
   end

   // A zero tick rate counts as no elapsed time.
   assign elapsed = (cfg.ticks_per_second == 20'd0) ? 32'd0 : quo_ff[31:0];

   always_comb begin
      zone_neg   = cfg.zone_hours[4];
      zone_mag   = zone_neg ? 5'd0 - cfg.zone_hours : cfg.zone_hours;
      zone_shift = {11'd0, zone_mag} * tlcd_pkg::SECS_PER_HOUR;
      if (zone_neg) begin
         local_t = ({16'd0, zone_shift} > utc_ff) ? 32'd0 : utc_ff - {16'd0, zone_shift};
      end else begin
         local_t = utc_ff + {16'd0, zone_shift};
      end
   end

   always_comb begin
      leap          = tlcd_pkg::is_leap(year_ff);
      year_len      = leap ? 9'd366 : 9'd365;
      mon_len       = tlcd_pkg::month_days(month_ff, leap);
      sts.year_end  = days_ff < {7'd0, year_len};
      sts.month_end = (month_ff == tlcd_pkg::LAST_MONTH) || (days_ff < {11'd0, mon_len});
   end

   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      dvs_in   = dvs_ff;
      utc_in   = utc_ff;
      sec_in   = sec_ff;
      min_in   = min_ff;
      hour_in  = hour_ff;
      year_in  = year_ff;
      month_in = month_ff;
      days_in  = days_ff;
      wd_in    = wd_ff;
      if (cmd.load_tick) begin
         quo_in = tick_now - cfg.base_tick_count;
         rem_in = '0;
         dvs_in = cfg.ticks_per_second;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[61:0], ge1, ge2};
         rem_in = rem2;
      end else if (cmd.latch_utc) begin
         utc_in = cfg.base_seconds + elapsed;
      end else if (cmd.load_local) begin
         quo_in = {local_t, 32'd0};
         rem_in = '0;
         dvs_in = {14'd0, tlcd_pkg::SECS_PER_MIN};
      end else if (cmd.load_min) begin
         sec_in = rem_ff[5:0];
         quo_in = {quo_ff[31:0], 32'd0};
         rem_in = '0;
         dvs_in = {14'd0, tlcd_pkg::MINS_PER_HOUR};
      end else if (cmd.load_hour) begin
         min_in = rem_ff[5:0];
         quo_in = {quo_ff[31:0], 32'd0};
         rem_in = '0;
         dvs_in = {14'd0, tlcd_pkg::HOURS_PER_DAY};
      end else if (cmd.start_cal) begin
         hour_in  = rem_ff[4:0];
         days_in  = quo_ff[15:0];
         year_in  = tlcd_pkg::FIRST_YEAR;
         month_in = 4'd1;
         wd_in    = tlcd_pkg::EPOCH_WEEKDAY;
      end else if (cmd.year_step) begin
         days_in = days_ff - {7'd0, year_len};
         year_in = year_ff + 12'd1;
         wd_in   = tlcd_pkg::add_mod7(wd_ff, leap ? 3'd2 : 3'd1);
      end else if (cmd.month_step) begin
         days_in  = days_ff - {11'd0, mon_len};
         month_in = month_ff + 4'd1;
         wd_in    = tlcd_pkg::add_mod7(wd_ff, 3'(mon_len - 5'd28));
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      dvs_ff   <= dvs_in;
      utc_ff   <= utc_in;
      sec_ff   <= sec_in;
      min_ff   <= min_in;
      hour_ff  <= hour_in;
      year_ff  <= year_in;
      month_ff <= month_in;
      days_ff  <= days_in;
      wd_ff    <= wd_in;
      if (cmd.finish) begin
         year_out_ff    <= year_ff;
         month_out_ff   <= month_ff;
         day_out_ff     <= days_ff[4:0] + 5'd1;
         hour_out_ff    <= hour_ff;
         minute_out_ff  <= min_ff;
         second_out_ff  <= sec_ff;
         weekday_out_ff <= tlcd_pkg::add_mod7(wd_ff, tlcd_pkg::mod7(days_ff[4:0]));
      end
   end

   assign year_out    = year_out_ff;
   assign month_out   = month_out_ff;
   assign day_out     = day_out_ff;
   assign hour_out    = hour_out_ff;
   assign minute_out  = minute_out_ff;
   assign second_out  = second_out_ff;
   assign weekday_out = weekday_out_ff;

   `TLCD_ASSERT_IMP(a_year_in_range, cmd.year_step, year_ff < tlcd_pkg::LAST_YEAR, "year walk past last year")
   `TLCD_ASSERT_IMP(a_month_in_range, cmd.month_step, month_ff < tlcd_pkg::LAST_MONTH, "month walk past December")
   `TLCD_ASSERT_NXT(a_day_valid, cmd.finish, (day_out_ff != 5'd0) && (weekday_out_ff < 3'd7), "bad day or weekday")

endmodule

// ===== hw/rtl/tlcd_ctrl.sv =====
// ============================================================================
// Tick to local calendar date: controller
// Sequences division, zone adjust and calendar walk; owns both handshakes.
// ============================================================================
`include "ticks_to_local_calendar_date_defines.svh"

module tlcd_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output tlcd_pkg::cmd_type  cmd,
   input  tlcd_pkg::sts_type  sts
);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'b0000000000001,
      ST_DIVT  = 13'b0000000000010,
      ST_UTC   = 13'b0000000000100,
      ST_LOCAL = 13'b0000000001000,
      ST_DIVS  = 13'b0000000010000,
      ST_LDMIN = 13'b0000000100000,
      ST_DIVM  = 13'b0000001000000,
      ST_LDHR  = 13'b0000010000000,
      ST_DIVH  = 13'b0000100000000,
      ST_CAL   = 13'b0001000000000,
      ST_YEAR  = 13'b0010000000000,
      ST_MONTH = 13'b0100000000000,
      ST_DONE  = 13'b1000000000000
   } state_type;

   localparam logic [4:0] DIV64_LAST = 5'd31;
   localparam logic [4:0] DIV32_LAST = 5'd15;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_tick = 1'b1;
               cnt_in        = DIV64_LAST;
               state_in      = ST_DIVT;
            end
         end
         ST_DIVT: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_UTC;
            end
         end
         ST_UTC: begin
            cmd.latch_utc = 1'b1;
            state_in      = ST_LOCAL;
         end
         ST_LOCAL: begin
            cmd.load_local = 1'b1;
            cnt_in         = DIV32_LAST;
            state_in       = ST_DIVS;
         end
         ST_DIVS: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_LDMIN;
            end
         end
         ST_LDMIN: begin
            cmd.load_min = 1'b1;
            cnt_in       = DIV32_LAST;
            state_in     = ST_DIVM;
         end
         ST_DIVM: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_LDHR;
            end
         end
         ST_LDHR: begin
            cmd.load_hour = 1'b1;
            cnt_in        = DIV32_LAST;
            state_in      = ST_DIVH;
         end
         ST_DIVH: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               state_in = ST_CAL;
            end
         end
         ST_CAL: begin
            cmd.start_cal = 1'b1;
            state_in      = ST_YEAR;
         end
         ST_YEAR: begin
            if (sts.year_end) begin
               state_in = ST_MONTH;
            end else begin
               cmd.year_step = 1'b1;
            end
         end
         ST_MONTH: begin
            if (sts.month_end) begin
               state_in = ST_DONE;
            end else begin
               cmd.month_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `TLCD_ASSERT_IMP(a_finish_free, cmd.finish, !rsp_valid_ff || !rsp_stall, "result overwritten")
   `TLCD_ASSERT_NXT(a_accept_starts, req_valid && !req_stall, state_ff == ST_DIVT, "accept did not start")
   `TLCD_ASSERT_IMP(a_valid_from_finish, $rose(rsp_valid_ff), $past(cmd.finish), "result without finish")

endmodule
